// ===== rtl/mces_pkg.sv =====
// Shared types and codes for the Markov-chain event sequencer.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package mces_pkg;

  // fixed field widths
  localparam int TICK_W  = 24;
  localparam int PHASE_W = 16;
  localparam int DRAW_W  = 15;
  localparam int VALUE_W = 32;
  localparam int CFG_W   = 24;

  // item function codes
  localparam logic [1:0] FN_TICK    = 2'd0;
  localparam logic [1:0] FN_TRIGGER = 2'd1;
  localparam logic [1:0] FN_WEIGHT  = 2'd2;
  localparam logic [1:0] FN_VALUE   = 2'd3;

  // configuration register indexes
  localparam logic [1:0] CFG_ACTIVE_STATES = 2'd0;
  localparam logic [1:0] CFG_SAMPLES       = 2'd1;
  localparam logic [1:0] CFG_MANUAL        = 2'd2;

  typedef struct packed {
    logic [1:0]               func;
    logic [DRAW_W-1:0]        random_draw;
    logic [3:0]               row_index;
    logic [3:0]               column_index;
    logic signed [VALUE_W-1:0] write_data;
  } mces_in_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] current_output;
    logic [PHASE_W-1:0]        sync_phase;
    logic [3:0]                state_index;
  } mces_out_t;

  // controller to datapath
  typedef struct packed {
    logic clr_step;
    logic load_item;
    logic exec_write;
    logic set_pending;
    logic clr_pending;
    logic tick_adv;
    logic draw_init;
    logic draw_rd;
    logic take_col;
    logic take_zero;
    logic step_col;
    logic val_rd;
    logic val_load;
    logic div_start;
    logic out_load;
  } mces_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [1:0] func;
    logic       clr_last;
    logic       manual;
    logic       pending;
    logic       wrap;
    logic       hit;
    logic       last_col;
    logic       div_done;
    logic       out_free;
  } mces_stat_t;

endpackage

// ===== rtl/mces_div.sv =====
// Serial restoring divider: Q0.16 phase = floor(count * 65536 / period).
// One quotient bit per cycle; uses mces_pkg widths.
`timescale 1ns / 1ps

module mces_div
  import mces_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [TICK_W-1:0]  dividend,
  input  logic [TICK_W-1:0]  divisor,
  output logic [PHASE_W-1:0] quotient,
  output logic               done
);

  localparam int CNT_W = $clog2(PHASE_W + 1);

  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [TICK_W-1:0]  rem_r;
  logic [PHASE_W-1:0] quo_r;
  logic [TICK_W:0]    trial;
  logic               fits;

  // shift remainder left and try the divisor
  assign trial = {rem_r, 1'b0};
  assign fits  = trial >= {1'b0, divisor};

  always_comb begin
    cnt_nxt = cnt_r;
    if (start) begin
      cnt_nxt = CNT_W'(PHASE_W);
    end else if (cnt_r != '0) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  // remainder and quotient carry no reset
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= dividend;
      quo_r <= '0;
    end else if (cnt_r != '0) begin
      if (fits) begin
        rem_r <= TICK_W'(trial - {1'b0, divisor});
      end else begin
        rem_r <= trial[TICK_W-1:0];
      end
      quo_r <= {quo_r[PHASE_W-2:0], fits};
    end
  end

  assign quotient = quo_r;
  assign done     = (cnt_r == CNT_W'(1));

endmodule

// ===== rtl/mces_dp.sv =====
// Datapath: config registers, weight and value memories, row walk,
// tick counter, output register. Uses mces_pkg and mces_div.
`timescale 1ns / 1ps

module mces_dp
  import mces_pkg::*;
#(
  parameter int MAX_STATES       = 16,
  parameter int WEIGHT_FRAC_BITS = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  mces_cmd_t        cmd,
  output mces_stat_t       st,
  input  mces_in_t         in_data,
  input  logic             cfg_valid,
  input  logic [1:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  input  logic             out_ready,
  output logic             out_valid,
  output mces_out_t        out_data
);

  localparam int SW     = $clog2(MAX_STATES);
  localparam int NW     = SW + 1;
  localparam int IW     = (SW > 4) ? SW : 4;
  localparam int WW     = WEIGHT_FRAC_BITS + 1;
  localparam int RW     = WEIGHT_FRAC_BITS + DRAW_W + 1;
  localparam int WDEPTH = 1 << (2 * SW);
  localparam int SDEPTH = 1 << SW;

  localparam logic [WW-1:0] W_ONE   = WW'(1 << WEIGHT_FRAC_BITS);
  localparam logic [WW-1:0] W_HALF  = WW'(1 << (WEIGHT_FRAC_BITS - 1));
  localparam logic [WW-1:0] W_QUART = WW'(1 << (WEIGHT_FRAC_BITS - 2));
  localparam logic [WW-1:0] W_THIRD = WW'(((33 << WEIGHT_FRAC_BITS) + 50) / 100);
  localparam logic [WW-1:0] W_MORE  = WW'(((34 << WEIGHT_FRAC_BITS) + 50) / 100);

  // reset pattern of the weight matrix
  function automatic logic [WW-1:0] dflt_weight(input int unsigned r, input int unsigned c);
    logic [WW-1:0] w;
    w = '0;
    if (r == 0 && (c == 1 || c == 2)) w = W_HALF;
    else if (r == 1 && c == 1) w = W_HALF;
    else if (r == 1 && (c == 0 || c == 3)) w = W_QUART;
    else if (r == 2 && c == 0) w = W_ONE;
    else if (r == 3 && (c == 0 || c == 1)) w = W_THIRD;
    else if (r == 3 && c == 2) w = W_MORE;
    return w;
  endfunction

  // reset pattern of the state values
  function automatic logic signed [VALUE_W-1:0] dflt_value(input int unsigned i);
    logic signed [VALUE_W-1:0] v;
    v = '0;
    if (i < 4) v = VALUE_W'(300 + 100 * i);
    return v;
  endfunction

  // configuration
  logic [4:0]        active_states_r;
  logic [TICK_W-1:0] samples_r;
  logic              manual_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_states_r <= 5'd4;
      samples_r       <= TICK_W'(44100);
      manual_r        <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_ACTIVE_STATES: active_states_r <= cfg_data[4:0];
        CFG_SAMPLES:       samples_r       <= cfg_data;
        CFG_MANUAL:        manual_r        <= cfg_data[0];
        default:           ;
      endcase
    end
  end

  // latched item
  mces_in_t item_r;

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item_r <= in_data;
    end
  end

  logic [IW-1:0] row_ext, col_ext;
  logic          row_ok, col_ok;
  logic [SW-1:0] row_s, col_s;

  assign row_ext = IW'(item_r.row_index);
  assign col_ext = IW'(item_r.column_index);
  assign row_s   = row_ext[SW-1:0];
  assign col_s   = col_ext[SW-1:0];
  assign row_ok  = {28'd0, item_r.row_index} < 32'(MAX_STATES);
  assign col_ok  = {28'd0, item_r.column_index} < 32'(MAX_STATES);

  // clearing pass counter
  logic [2*SW-1:0] clr_addr_r;
  logic [SW-1:0]   clr_row, clr_col;

  assign clr_row = clr_addr_r[2*SW-1:SW];
  assign clr_col = clr_addr_r[SW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
    end else if (cmd.clr_step) begin
      clr_addr_r <= clr_addr_r + 1'b1;
    end
  end

  // saturate incoming weight to 0 .. one
  logic [WW-1:0] sat_weight;

  always_comb begin
    if (item_r.write_data[VALUE_W-1]) begin
      sat_weight = '0;
    end else if (item_r.write_data[VALUE_W-2:0] > 31'(1 << WEIGHT_FRAC_BITS)) begin
      sat_weight = W_ONE;
    end else begin
      sat_weight = item_r.write_data[WW-1:0];
    end
  end

  // walk registers
  logic [SW-1:0]   present_r;
  logic [SW-1:0]   col_r;
  logic [RW-1:0]   rem_r;
  logic [WW-1:0]   w_rdata_r;
  logic [RW-1:0]   w_ext;
  logic [NW-1:0]   n_val;

  // weight memory: one write port, one registered read port
  logic [WW-1:0]   wmem [WDEPTH];
  logic            w_we;
  logic [2*SW-1:0] w_waddr;
  logic [WW-1:0]   w_wdata;

  always_comb begin
    if (cmd.clr_step) begin
      w_we    = 1'b1;
      w_waddr = clr_addr_r;
      w_wdata = dflt_weight(32'(clr_row), 32'(clr_col));
    end else begin
      w_we    = cmd.exec_write && (item_r.func == FN_WEIGHT) && row_ok && col_ok;
      w_waddr = {row_s, col_s};
      w_wdata = sat_weight;
    end
  end

  always_ff @(posedge clk) begin
    if (w_we) begin
      wmem[w_waddr] <= w_wdata;
    end
    if (cmd.draw_rd) begin
      w_rdata_r <= wmem[{present_r, col_r}];
    end
  end

  // state value memory
  logic signed [VALUE_W-1:0] smem [SDEPTH];
  logic signed [VALUE_W-1:0] s_rdata_r;
  logic                      s_we;
  logic [SW-1:0]             s_waddr;
  logic signed [VALUE_W-1:0] s_wdata;

  always_comb begin
    if (cmd.clr_step) begin
      s_we    = (clr_row == '0);
      s_waddr = clr_col;
      s_wdata = dflt_value(32'(clr_col));
    end else begin
      s_we    = cmd.exec_write && (item_r.func == FN_VALUE) && row_ok;
      s_waddr = row_s;
      s_wdata = item_r.write_data;
    end
  end

  always_ff @(posedge clk) begin
    if (s_we) begin
      smem[s_waddr] <= s_wdata;
    end
    if (cmd.val_rd) begin
      s_rdata_r <= smem[present_r];
    end
  end

  // row walk: subtract weights until the remaining draw falls below the current column's weight
  assign w_ext = {w_rdata_r, {DRAW_W{1'b0}}};

  always_comb begin
    if (active_states_r == '0) begin
      n_val = NW'(1);
    end else if (32'(active_states_r) > 32'(MAX_STATES)) begin
      n_val = NW'(MAX_STATES);
    end else begin
      n_val = NW'(active_states_r);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.draw_init) begin
      rem_r <= {1'b0, item_r.random_draw, {WEIGHT_FRAC_BITS{1'b0}}};
      col_r <= '0;
    end else if (cmd.step_col) begin
      rem_r <= rem_r - w_ext;
      col_r <= col_r + 1'b1;
    end
  end

  // tick counter and period
  logic [TICK_W-1:0] tick_r;
  logic [TICK_W-1:0] period;
  logic [TICK_W:0]   tick_inc;

  assign period   = (samples_r == '0) ? TICK_W'(1) : samples_r;
  assign tick_inc = {1'b0, tick_r} + 1'b1;

  // state, held value, trigger flag
  logic                      pending_r;
  logic signed [VALUE_W-1:0] held_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      present_r <= '0;
      held_r    <= VALUE_W'(300);
      tick_r    <= '0;
      pending_r <= 1'b0;
    end else begin
      if (cmd.take_col) begin
        present_r <= col_r;
      end else if (cmd.take_zero) begin
        present_r <= '0;
      end
      if (cmd.val_load) begin
        held_r <= s_rdata_r;
      end
      if (cmd.tick_adv) begin
        tick_r <= st.wrap ? '0 : tick_inc[TICK_W-1:0];
      end
      if (cmd.set_pending) begin
        pending_r <= 1'b1;
      end else if (cmd.clr_pending) begin
        pending_r <= 1'b0;
      end
    end
  end

  // phase divider
  logic [PHASE_W-1:0] div_q;
  logic               div_done;

  mces_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (tick_r),
    .divisor  (period),
    .quotient (div_q),
    .done     (div_done)
  );

  // output register
  logic      out_valid_r;
  mces_out_t out_data_r;
  logic [IW-1:0] present_ext;

  assign present_ext = IW'(present_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data_r.current_output <= held_r;
      out_data_r.sync_phase     <= manual_r ? '0 : div_q;
      out_data_r.state_index    <= present_ext[3:0];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // status
  assign st.func     = item_r.func;
  assign st.clr_last = &clr_addr_r;
  assign st.manual   = manual_r;
  assign st.pending  = pending_r;
  assign st.wrap     = tick_inc >= {1'b0, period};
  assign st.hit      = rem_r < w_ext;
  assign st.last_col = ({1'b0, col_r} + NW'(1)) == n_val;
  assign st.div_done = div_done;
  assign st.out_free = !out_valid_r || out_ready;

  a_state_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(present_r) < 32'(MAX_STATES))
    else $error("present state beyond state count");

  a_tick_below_period: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.tick_adv |=> tick_r < $past(period))
    else $error("tick counter not below period after advance");

endmodule

// ===== rtl/mces_ctrl.sv =====
// Controller state machine: sequences clearing, item decode, row walk,
// value fetch, phase division and output load. Uses mces_pkg.
`timescale 1ns / 1ps

module mces_ctrl
  import mces_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  mces_stat_t st,
  output mces_cmd_t  cmd
);

  localparam logic [3:0] S_CLEAR     = 4'd0;
  localparam logic [3:0] S_IDLE      = 4'd1;
  localparam logic [3:0] S_EXEC      = 4'd2;
  localparam logic [3:0] S_DRAW_RD   = 4'd3;
  localparam logic [3:0] S_DRAW_CMP  = 4'd4;
  localparam logic [3:0] S_VAL_RD    = 4'd5;
  localparam logic [3:0] S_VAL_LD    = 4'd6;
  localparam logic [3:0] S_DIV_START = 4'd7;
  localparam logic [3:0] S_DIV_WAIT  = 4'd8;
  localparam logic [3:0] S_OUT       = 4'd9;

  logic [3:0] state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (st.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_nxt     = S_EXEC;
        end
      end
      S_EXEC: begin
        case (st.func)
          FN_TRIGGER: begin
            cmd.set_pending = 1'b1;
            state_nxt       = S_IDLE;
          end
          FN_WEIGHT, FN_VALUE: begin
            cmd.exec_write = 1'b1;
            state_nxt      = S_IDLE;
          end
          default: begin
            if (st.manual) begin
              if (st.pending) begin
                cmd.clr_pending = 1'b1;
                cmd.draw_init   = 1'b1;
                state_nxt       = S_DRAW_RD;
              end else begin
                state_nxt = S_OUT;
              end
            end else begin
              cmd.tick_adv = 1'b1;
              if (st.wrap) begin
                cmd.draw_init = 1'b1;
                state_nxt     = S_DRAW_RD;
              end else begin
                state_nxt = S_DIV_START;
              end
            end
          end
        endcase
      end
      S_DRAW_RD: begin
        cmd.draw_rd = 1'b1;
        state_nxt   = S_DRAW_CMP;
      end
      S_DRAW_CMP: begin
        if (st.hit) begin
          cmd.take_col = 1'b1;
          state_nxt    = S_VAL_RD;
        end else if (st.last_col) begin
          cmd.take_zero = 1'b1;
          state_nxt     = S_VAL_RD;
        end else begin
          cmd.step_col = 1'b1;
          state_nxt    = S_DRAW_RD;
        end
      end
      S_VAL_RD: begin
        cmd.val_rd = 1'b1;
        state_nxt  = S_VAL_LD;
      end
      S_VAL_LD: begin
        cmd.val_load = 1'b1;
        state_nxt    = st.manual ? S_OUT : S_DIV_START;
      end
      S_DIV_START: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (st.div_done) state_nxt = S_OUT;
      end
      S_OUT: begin
        // hold until the output register is free
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> st.out_free)
    else $error("result word loaded over an untaken word");

  a_div_done_waiting: assert property (@(posedge clk) disable iff (!rst_n)
    st.div_done |-> (state_r == S_DIV_WAIT))
    else $error("divider finished outside its wait state");

endmodule

// ===== rtl/markov_chain_event_sequencer_top.sv =====
// Weight, value and trigger words are accepted, then executed. A timed tick advances the
// tick counter, walks a row of up to active_states columns when it wraps, then divides;
// a manual tick walks a row only on a pending trigger and skips the divider. One word is
// taken at a time: in_ready rises again in the cycle after the result loads; the single
// weight read port, 1-bit/cycle divider and out stalls set the accept rate. Reset:
// control and config return to defaults, then, with in_ready low, a pass over
// 2^(2*ceil(log2 MAX_STATES)) addresses (256 by default) loads default weights and values.
`timescale 1ns / 1ps

module markov_chain_event_sequencer_top
  import mces_pkg::*;
#(
  parameter int MAX_STATES       = 16,
  parameter int WEIGHT_FRAC_BITS = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  mces_in_t         in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output mces_out_t        out_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [1:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

  mces_cmd_t  cmd;
  mces_stat_t st;

  // configuration writes are always accepted and land in the config registers
  assign cfg_ready = 1'b1;

  mces_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  mces_dp #(
    .MAX_STATES       (MAX_STATES),
    .WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .st        (st),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule
